// ----- rtl/mbl_pkg.sv -----
// Shared widths, codes and types for the eight-lane escape-time block.
package mbl_pkg;

  localparam int LANES     = 8;
  localparam int FRAC_BITS = 24;
  localparam int COORD_W   = 32;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int CNT_W     = 9;
  localparam int ITER_W    = 9;
  localparam int K_W       = 8;
  localparam int RSQ_W     = 14;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int IN_W      = 2 * COORD_W;
  localparam int OUT_W     = ((LANES * CNT_W + 7) / 8) * 8;

  localparam logic [ITER_W-1:0]  ITER_CAP   = ITER_W'(256);
  localparam logic [CNT_W-1:0]   COUNT_NONE = {CNT_W{1'b1}};

  localparam logic [COORD_W-1:0] STEP_RE_RST  = COORD_W'(41943);
  localparam logic [ITER_W-1:0]  MAX_ITER_RST = ITER_W'(256);
  localparam logic [RSQ_W-1:0]   RSQ_RST      = RSQ_W'(100);

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RSQ      = CFG_IDX_W'(2);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MUL   = 4'b0010,
    S_EVAL  = 4'b0100,
    S_FLUSH = 4'b1000
  } mbl_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic eval;
  } lane_ctl_t;

endpackage

// ----- rtl/mandelbrot_escape_eight_lane.sv -----
// Top level: eight escape-time lanes, configuration registers and result register.
//
// Usage:
//   in_*  : one item per pixel group: lane-0 real coordinate and the shared
//           imaginary coordinate, both signed Q8.24. Lane i works on
//           start_re + i * step_re.
//   out_* : one item per input item: eight 9-bit escape counts, -1 when a
//           lane stays bounded for all tried iterations.
//   cfg_* : step_re, max_iter and escape_radius_sq; write only while idle.
// Sequence: each iteration runs S_MUL, which registers the three lane
//   products, then S_EVAL, which tests and forms the next point. An item
//   runs n iterations after acceptance, then S_FLUSH loads its result; n is
//   max_iter (capped at 256), or fewer once all lanes have escaped. The next
//   item can be taken in the cycle after the result is loaded.
// Reset: synchronous, active low; control and configuration registers
//   return to their reset values and no result is pending.
// Stall: a result waits in the output register while out_tready is low; a new
//   item is still taken and computed, and its result holds in the lanes until
//   the output register frees up.
module mandelbrot_escape_eight_lane
  import mbl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // start_re, coord_im
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // count_lane0 .. count_lane7
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [COORD_W-1:0] step_re_r;
  logic [ITER_W-1:0]  max_iter_r, limit;
  logic [RSQ_W-1:0]   rsq_r;

  lane_ctl_t          lane_ctl;
  logic [K_W-1:0]     iter;
  logic [LANES-1:0]   settled;
  logic [CNT_W-1:0]   count [LANES];
  logic [COORD_W-1:0] start_re, coord_im;
  logic               out_free, out_load;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r, out_data_nxt;

  assign start_re = in_tdata[0 +: COORD_W];
  assign coord_im = in_tdata[COORD_W +: COORD_W];
  assign limit    = (max_iter_r > ITER_CAP) ? ITER_CAP : max_iter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_re_r  <= STEP_RE_RST;
      max_iter_r <= MAX_ITER_RST;
      rsq_r      <= RSQ_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_RE:  step_re_r  <= cfg_wdata[COORD_W-1:0];
        CFG_MAX_ITER: max_iter_r <= cfg_wdata[ITER_W-1:0];
        CFG_RSQ:      rsq_r      <= cfg_wdata[RSQ_W-1:0];
        default: ;
      endcase
    end
  end

  mbl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .limit_i    (limit),
    .settled_i  (settled),
    .out_free_i (out_free),
    .in_tready  (in_tready),
    .lane_ctl   (lane_ctl),
    .iter_o     (iter),
    .out_load_o (out_load)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [COORD_W-1:0] lane_re;

    // Wraps modulo 2^32 like the coordinate field.
    assign lane_re = start_re + COORD_W'(COORD_W'(i) * step_re_r);

    mbl_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (lane_ctl),
      .c_re_i    (lane_re),
      .c_im_i    (coord_im),
      .iter_i    (iter),
      .rsq_i     (rsq_r),
      .settled_o (settled[i]),
      .count_o   (count[i])
    );
  end

  always_comb begin
    out_data_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      out_data_nxt[i*CNT_W +: CNT_W] = count[i];
    end
  end

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/mbl_lane.sv -----
// One lane: complex square, escape test and count for a single pixel.
module mbl_lane
  import mbl_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  lane_ctl_t                  ctl,
  input  logic signed [COORD_W-1:0]  c_re_i,
  input  logic signed [COORD_W-1:0]  c_im_i,
  input  logic [K_W-1:0]             iter_i,
  input  logic [RSQ_W-1:0]           rsq_i,
  output logic                       settled_o,
  output logic [CNT_W-1:0]           count_o
);

  logic signed [COORD_W-1:0] c_re_r, c_im_r, z_re_r, z_im_r;
  logic signed [PROD_W-1:0]  rr_r, ii_r, ri_r;
  logic signed [PROD_W-1:0]  rr_nxt, ii_nxt, ri_nxt, diff;
  logic [PROD_W-1:0]         mag_sq, thresh;
  logic [COORD_W-1:0]        re_nxt, im_nxt;
  logic                      done_r, esc;
  logic [CNT_W-1:0]          cnt_r;

  assign rr_nxt = PROD_W'(z_re_r) * PROD_W'(z_re_r);
  assign ii_nxt = PROD_W'(z_im_r) * PROD_W'(z_im_r);
  assign ri_nxt = PROD_W'(z_re_r) * PROD_W'(z_im_r);

  // Exact squared magnitude; both squares are non-negative, so no overflow.
  assign mag_sq = $unsigned(rr_r) + $unsigned(ii_r);
  assign thresh = PROD_W'(rsq_i) << (2 * FRAC_BITS);
  assign esc    = ctl.eval && !done_r && (mag_sq > thresh);

  // Floor shift then wrap to 32 bits: the kept slice of the exact value.
  assign diff   = rr_r - ii_r;
  assign re_nxt = diff[FRAC_BITS +: COORD_W] + c_re_r;
  assign im_nxt = ri_r[FRAC_BITS-1 +: COORD_W] + c_im_r;

  assign settled_o = done_r || esc;
  assign count_o   = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else if (ctl.load) begin
      done_r <= 1'b0;
    end else if (esc) begin
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      c_re_r <= c_re_i;
      c_im_r <= c_im_i;
      z_re_r <= c_re_i;
      z_im_r <= c_im_i;
      cnt_r  <= COUNT_NONE;
    end else if (ctl.mul) begin
      rr_r <= rr_nxt;
      ii_r <= ii_nxt;
      ri_r <= ri_nxt;
    end else if (ctl.eval) begin
      if (esc) begin
        cnt_r <= CNT_W'(iter_i);
      end else if (!done_r) begin
        z_re_r <= re_nxt;
        z_im_r <= im_nxt;
      end
    end
  end

endmodule

// ----- rtl/mbl_ctrl.sv -----
// Iteration sequencer: shared step counter and merge of the lane escape flags.
module mbl_ctrl
  import mbl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [ITER_W-1:0] limit_i,
  input  logic [LANES-1:0]  settled_i,
  input  logic              out_free_i,
  output logic              in_tready,
  output lane_ctl_t         lane_ctl,
  output logic [K_W-1:0]    iter_o,
  output logic              out_load_o
);

  mbl_state_t     state_r, state_nxt;
  logic [K_W-1:0] k_r, k_nxt;
  logic           accept, last_iter, all_settled;

  assign in_tready   = (state_r == S_IDLE);
  assign accept      = in_tready && in_tvalid;
  assign all_settled = &settled_i;
  assign last_iter   = ({1'b0, k_r} == ITER_W'(limit_i - 1'b1));

  assign lane_ctl.load = accept;
  assign lane_ctl.mul  = (state_r == S_MUL);
  assign lane_ctl.eval = (state_r == S_EVAL);
  assign out_load_o    = (state_r == S_FLUSH) && out_free_i;
  assign iter_o        = k_r;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          k_nxt = '0;
          // A zero limit runs no iteration: every lane keeps its none code.
          state_nxt = (limit_i == '0) ? S_FLUSH : S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (all_settled || last_iter) begin
          state_nxt = S_FLUSH;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_FLUSH: begin
        if (out_free_i) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

// ----- rtl/mbl_checker.sv -----
// Port-level checks for the escape-time block, bound to the top level.
module mbl_checker
  import mbl_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [OUT_W-1:0]     out_tdata
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // An accepted item keeps the input closed for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input open right after accepting an item");

  // A count is either the none code or an iteration index below 256.
  for (genvar i = 0; i < LANES; i++) begin : g_cnt
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && out_tdata[i*CNT_W + CNT_W - 1] |->
        out_tdata[i*CNT_W +: CNT_W] == COUNT_NONE)
      else $error("lane count out of range");
  end

endmodule

bind mandelbrot_escape_eight_lane mbl_checker u_mbl_checker (.*);
